### rtl/core/tcba_pkg.sv
// Shared types, codes and defaults for the three-class block allocator.
package tcba_pkg;

    // Default block counts per class
    localparam int SMALL_BLOCKS_DEF = 256;
    localparam int MID_BLOCKS_DEF   = 128;
    localparam int LARGE_BLOCKS_DEF = 64;

    // Field widths
    localparam int SIZE_W    = 20;
    localparam int ADDR_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    // Wide enough for a fresh-block count of up to 65536
    localparam int USED_W    = 17;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_TOO_LARGE     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FREE_OVERSIZE = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW      = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_BASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BASE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_BASE   = 3'd6;

    // Configuration reset values
    localparam logic [SIZE_W-1:0] RST_SMALL_SIZE = 20'd64;
    localparam logic [SIZE_W-1:0] RST_MID_SIZE   = 20'd512;
    localparam logic [SIZE_W-1:0] RST_LARGE_SIZE = 20'd4096;
    localparam logic [ADDR_W-1:0] RST_SMALL_BASE = 32'd0;
    localparam logic [ADDR_W-1:0] RST_MID_BASE   = 32'd16384;
    localparam logic [ADDR_W-1:0] RST_LARGE_BASE = 32'd81920;
    localparam logic [ADDR_W-1:0] RST_MEM_BASE   = 32'd65536;

    // Request and result payloads
    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   block_address;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // Size class, one-hot
    typedef enum logic [2:0] {
        CLS_SMALL = 3'b001,
        CLS_MID   = 3'b010,
        CLS_LARGE = 3'b100
    } cls_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

    // Datapath to one class stack
    typedef struct packed {
        logic rd_en;
        logic pop;
        logic push;
        logic fresh;
    } stk_cmd_t;

    // Class stack status
    typedef struct packed {
        logic              empty;
        logic              full;
        logic              used_full;
        logic [USED_W-1:0] used;
    } stk_stat_t;

endpackage

### rtl/core/tcba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/tcba_class_stack.sv
// One size class: LIFO of freed offsets, its fill count and fresh-block count.
module tcba_class_stack #(
    parameter int DEPTH = tcba_pkg::SMALL_BLOCKS_DEF
) (
    input  logic                        clk,
    input  logic                        rstn,
    input  tcba_pkg::stk_cmd_t          cmd,
    input  logic [tcba_pkg::ADDR_W-1:0] wdata,
    output logic [tcba_pkg::ADDR_W-1:0] rdata,
    output tcba_pkg::stk_stat_t         stat
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] count_m1;

    assign count_m1 = count_reg - CW'(1);

    // Top of stack is read on capture, a push writes above it on commit
    tcba_ram #(
        .WIDTH (tcba_pkg::ADDR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (count_m1[AW-1:0]),
        .rdata (rdata)
    );

    // Advance fill and fresh counts
    always_comb begin
        count_next = count_reg;
        used_next  = used_reg;
        if (cmd.pop) begin
            count_next = count_m1;
        end else if (cmd.push) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.fresh) begin
            used_next = used_reg + CW'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            count_reg <= '0;
            used_reg  <= '0;
        end else begin
            count_reg <= count_next;
            used_reg  <= used_next;
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == DEPTH_C);
    assign stat.used_full = (used_reg == DEPTH_C);
    assign stat.used      = tcba_pkg::USED_W'(used_reg);

endmodule

### rtl/core/tcba_datapath.sv
// Datapath: configuration registers, class select, offset math, result register.
module tcba_datapath #(
    parameter int SMALL_BLOCKS = tcba_pkg::SMALL_BLOCKS_DEF,
    parameter int MID_BLOCKS   = tcba_pkg::MID_BLOCKS_DEF,
    parameter int LARGE_BLOCKS = tcba_pkg::LARGE_BLOCKS_DEF
) (
    input  logic                            clk,
    input  logic                            rstn,
    input  tcba_pkg::dp_cmd_t               cmd,
    input  tcba_pkg::req_t                  req,
    output tcba_pkg::rsp_t                  rsp,
    input  logic                            cfg_we,
    input  logic [tcba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcba_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = tcba_pkg::ADDR_W;
    localparam int SW = tcba_pkg::SIZE_W;
    localparam int UW = tcba_pkg::USED_W;

    // Configuration
    logic [SW-1:0] small_size_reg, mid_size_reg, large_size_reg;
    logic [AW-1:0] small_base_reg, mid_base_reg, large_base_reg, memory_base_reg;

    // Captured request
    logic            mode_reg;
    logic            too_big_reg;
    tcba_pkg::cls_t  cls_reg;
    logic [AW-1:0]   fresh_base_reg;
    logic [AW-1:0]   prod_reg;
    logic [AW-1:0]   free_off_reg;
    tcba_pkg::rsp_t  rsp_reg;

    // Capture-side logic
    logic              too_big_c;
    tcba_pkg::cls_t    cls_c;
    logic [UW-1:0]     used_sel_c;
    logic [SW-1:0]     bsize_sel_c;
    logic [AW-1:0]     base_sel_c;
    logic [UW+SW-1:0]  prod_c;

    // Commit-side logic
    tcba_pkg::stk_stat_t stat_s, stat_m, stat_l, stat_sel;
    logic [AW-1:0]       rdata_s, rdata_m, rdata_l, rdata_sel;
    tcba_pkg::stk_cmd_t  cmd_s, cmd_m, cmd_l;
    logic                pop_c, push_c, fresh_c;
    logic [AW-1:0]       addr_c;
    logic [tcba_pkg::STATUS_W-1:0] status_c;

    // Write configuration registers
    always_ff @(posedge clk) begin
        if (!rstn) begin
            small_size_reg  <= tcba_pkg::RST_SMALL_SIZE;
            mid_size_reg    <= tcba_pkg::RST_MID_SIZE;
            large_size_reg  <= tcba_pkg::RST_LARGE_SIZE;
            small_base_reg  <= tcba_pkg::RST_SMALL_BASE;
            mid_base_reg    <= tcba_pkg::RST_MID_BASE;
            large_base_reg  <= tcba_pkg::RST_LARGE_BASE;
            memory_base_reg <= tcba_pkg::RST_MEM_BASE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tcba_pkg::CFG_SMALL_SIZE: small_size_reg  <= cfg_data[SW-1:0];
                tcba_pkg::CFG_MID_SIZE:   mid_size_reg    <= cfg_data[SW-1:0];
                tcba_pkg::CFG_LARGE_SIZE: large_size_reg  <= cfg_data[SW-1:0];
                tcba_pkg::CFG_SMALL_BASE: small_base_reg  <= cfg_data[AW-1:0];
                tcba_pkg::CFG_MID_BASE:   mid_base_reg    <= cfg_data[AW-1:0];
                tcba_pkg::CFG_LARGE_BASE: large_base_reg  <= cfg_data[AW-1:0];
                tcba_pkg::CFG_MEM_BASE:   memory_base_reg <= cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // Pick the class: large test first, then mid, else small
    always_comb begin
        too_big_c = (req.request_size > large_size_reg);
        if (req.request_size > mid_size_reg) begin
            cls_c = tcba_pkg::CLS_LARGE;
        end else if (req.request_size > small_size_reg) begin
            cls_c = tcba_pkg::CLS_MID;
        end else begin
            cls_c = tcba_pkg::CLS_SMALL;
        end
    end

    // Select the class's fresh count, block size and region base
    always_comb begin
        case (cls_c)
            tcba_pkg::CLS_LARGE: begin
                used_sel_c  = stat_l.used;
                bsize_sel_c = large_size_reg;
                base_sel_c  = large_base_reg;
            end
            tcba_pkg::CLS_MID: begin
                used_sel_c  = stat_m.used;
                bsize_sel_c = mid_size_reg;
                base_sel_c  = mid_base_reg;
            end
            default: begin
                used_sel_c  = stat_s.used;
                bsize_sel_c = small_size_reg;
                base_sel_c  = small_base_reg;
            end
        endcase
        prod_c = used_sel_c * bsize_sel_c;
    end

    // Hold the request and its partial results until commit
    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            mode_reg       <= req.mode;
            too_big_reg    <= too_big_c;
            cls_reg        <= cls_c;
            fresh_base_reg <= base_sel_c + memory_base_reg;
            prod_reg       <= prod_c[AW-1:0];
            free_off_reg   <= req.free_address - memory_base_reg;
        end
    end

    // Per-class stacks
    tcba_class_stack #(.DEPTH(SMALL_BLOCKS)) u_small (
        .clk (clk), .rstn (rstn), .cmd (cmd_s), .wdata (free_off_reg),
        .rdata (rdata_s), .stat (stat_s)
    );

    tcba_class_stack #(.DEPTH(MID_BLOCKS)) u_mid (
        .clk (clk), .rstn (rstn), .cmd (cmd_m), .wdata (free_off_reg),
        .rdata (rdata_m), .stat (stat_m)
    );

    tcba_class_stack #(.DEPTH(LARGE_BLOCKS)) u_large (
        .clk (clk), .rstn (rstn), .cmd (cmd_l), .wdata (free_off_reg),
        .rdata (rdata_l), .stat (stat_l)
    );

    // Select the captured class's stack view
    always_comb begin
        case (cls_reg)
            tcba_pkg::CLS_LARGE: begin
                stat_sel  = stat_l;
                rdata_sel = rdata_l;
            end
            tcba_pkg::CLS_MID: begin
                stat_sel  = stat_m;
                rdata_sel = rdata_m;
            end
            default: begin
                stat_sel  = stat_s;
                rdata_sel = rdata_s;
            end
        endcase
    end

    // Decide pop, fresh block, push or refusal
    always_comb begin
        pop_c    = 1'b0;
        push_c   = 1'b0;
        fresh_c  = 1'b0;
        addr_c   = '0;
        status_c = tcba_pkg::STAT_OK;
        if (too_big_reg) begin
            status_c = (mode_reg == tcba_pkg::MODE_FREE) ?
                       tcba_pkg::STAT_FREE_OVERSIZE : tcba_pkg::STAT_TOO_LARGE;
        end else if (mode_reg == tcba_pkg::MODE_ALLOC) begin
            if (!stat_sel.empty) begin
                pop_c  = 1'b1;
                addr_c = memory_base_reg + rdata_sel;
            end else if (!stat_sel.used_full) begin
                fresh_c = 1'b1;
                addr_c  = fresh_base_reg + prod_reg;
            end else begin
                status_c = tcba_pkg::STAT_EXHAUSTED;
            end
        end else begin
            if (!stat_sel.full) begin
                push_c = 1'b1;
            end else begin
                status_c = tcba_pkg::STAT_OVERFLOW;
            end
        end
    end

    // All stacks read on capture; pop, push and fresh go to the captured class only
    always_comb begin
        cmd_s.rd_en = cmd.capture;
        cmd_m.rd_en = cmd.capture;
        cmd_l.rd_en = cmd.capture;
        cmd_s.pop   = cmd.commit && pop_c   && (cls_reg == tcba_pkg::CLS_SMALL);
        cmd_s.push  = cmd.commit && push_c  && (cls_reg == tcba_pkg::CLS_SMALL);
        cmd_s.fresh = cmd.commit && fresh_c && (cls_reg == tcba_pkg::CLS_SMALL);
        cmd_m.pop   = cmd.commit && pop_c   && (cls_reg == tcba_pkg::CLS_MID);
        cmd_m.push  = cmd.commit && push_c  && (cls_reg == tcba_pkg::CLS_MID);
        cmd_m.fresh = cmd.commit && fresh_c && (cls_reg == tcba_pkg::CLS_MID);
        cmd_l.pop   = cmd.commit && pop_c   && (cls_reg == tcba_pkg::CLS_LARGE);
        cmd_l.push  = cmd.commit && push_c  && (cls_reg == tcba_pkg::CLS_LARGE);
        cmd_l.fresh = cmd.commit && fresh_c && (cls_reg == tcba_pkg::CLS_LARGE);
    end

    // Load the result register on commit
    always_ff @(posedge clk) begin
        if (cmd.commit) begin
            rsp_reg.block_address <= addr_c;
            rsp_reg.status        <= status_c;
        end
    end

    assign rsp = rsp_reg;

endmodule

### rtl/core/tcba_ctrl.sv
// Controller: request sequencing and result-valid handshake.
module tcba_ctrl (
    input  logic              clk,
    input  logic              rstn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output tcba_pkg::dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready     = (state_reg == ST_IDLE);
    assign cmd.capture = s_valid && s_ready;
    assign cmd.commit  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    // Advance the state machine
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### rtl/core/three_class_block_allocator_core.sv
// Top level of the three-class fixed-block allocator.
//
// Requests arrive on s_valid/s_ready with s_payload (mode, request_size,
// free_address); one result per request leaves on m_valid/m_ready with
// m_payload (block_address, status). Configuration registers are written on
// cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data; the user
// must write them only while no request is in flight, which the block does
// not enforce. In the accept cycle the class is chosen, the class's stack
// memory is read at its top and the fresh-block product (count times block
// size) is registered; in the commit cycle, which waits while an earlier
// result is still held and not taken, the stack is popped or pushed and the
// result register is loaded. A new request is accepted only after the
// previous one has committed.
// The output register lets the next request be accepted while a result
// still waits; if the receiver stalls past that, the second request holds
// in its commit cycle and s_ready stays low.
// Synchronous reset (aresetn low) restores the configuration defaults and
// empties all stacks and fresh counts at once; no clearing pass is needed.
module three_class_block_allocator_core #(
    parameter int SMALL_BLOCKS = tcba_pkg::SMALL_BLOCKS_DEF,
    parameter int MID_BLOCKS   = tcba_pkg::MID_BLOCKS_DEF,
    parameter int LARGE_BLOCKS = tcba_pkg::LARGE_BLOCKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tcba_pkg::req_t                  s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tcba_pkg::rsp_t                  m_payload,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcba_pkg::CFG_DATA_W-1:0] cfg_data
);

    tcba_pkg::dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    tcba_ctrl u_ctrl (
        .clk     (aclk),
        .rstn    (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tcba_datapath #(
        .SMALL_BLOCKS (SMALL_BLOCKS),
        .MID_BLOCKS   (MID_BLOCKS),
        .LARGE_BLOCKS (LARGE_BLOCKS)
    ) u_dp (
        .clk       (aclk),
        .rstn      (aresetn),
        .cmd       (cmd),
        .req       (s_payload),
        .rsp       (m_payload),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### rtl/core/tcba_checker.sv
// Port-level assertions for the allocator core, bound to the top level.
module tcba_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input tcba_pkg::rsp_t m_payload
);

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // One request in flight: ready drops after an accept
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // Status is a defined code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.status == tcba_pkg::STAT_OK ||
                     m_payload.status == tcba_pkg::STAT_TOO_LARGE ||
                     m_payload.status == tcba_pkg::STAT_EXHAUSTED ||
                     m_payload.status == tcba_pkg::STAT_FREE_OVERSIZE ||
                     m_payload.status == tcba_pkg::STAT_OVERFLOW))
        else $error("undefined status code");

    // Any failure returns a zero address
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status != tcba_pkg::STAT_OK) |->
            (m_payload.block_address == '0))
        else $error("failed request returned a nonzero address");

    // Reset drops the result valid
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind three_class_block_allocator_core tcba_checker u_tcba_checker (.*);
